### design/pbsd_pkg.sv
// Shared types and codes for the protobuf stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package pbsd_pkg;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_INT  = 3'd0,
    KIND_HDR  = 3'd1,
    KIND_DATA = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BAD_LEN = 3'd1,
    ERR_WIRE    = 3'd2,
    ERR_VARINT  = 3'd3,
    ERR_OVERRUN = 3'd4,
    ERR_TRUNC   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  localparam int unsigned LenW   = 21;
  localparam int unsigned FieldW = 32;
  localparam int unsigned ValueW = 64;

  localparam logic [LenW-1:0] MaxLenReset = 21'h100000;

  localparam logic [2:0] WireVarint = 3'd0;
  localparam logic [2:0] WireLenDel = 3'd2;

  typedef struct packed {
    logic              final_of_input;
    kind_e             kind;
    err_e              err_code;
    logic              last_of_field;
    logic [7:0]        payload_byte;
    logic [ValueW-1:0] value;
    logic [FieldW-1:0] field_number;
  } res_t;

endpackage

`default_nettype wire

### design/pbsd_core.sv
// Parser state and per-byte decode: key, varint, length and data phases.
// Depends on pbsd_pkg; produces up to two results per request.
`default_nettype none

module pbsd_core import pbsd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 1048576
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  input  wire logic            step_i,
  input  wire cmd_e            cmd_i,
  input  wire logic [LenW-1:0] len_i,
  input  wire logic [7:0]      byte_i,
  output logic [1:0]           res_cnt_o,
  output res_t                 res0_o,
  output res_t                 res1_o
);

  logic [LenW-1:0]   max_len_q;
  logic              in_msg_q, in_msg_d;
  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [3:0]        vcnt_q, vcnt_d;
  logic [FieldW-1:0] field_q, field_d;
  logic [LenW-1:0]   frem_q, frem_d;

  logic [5:0]        shamt;
  logic [ValueW-1:0] acc_new;
  logic              prim_v;
  kind_e             prim_kind;
  err_e              fail_code;
  logic              comp;
  res_t              prim_res;
  res_t              comp_res;

  assign shamt   = {2'b00, vcnt_q} * 6'd7;
  assign acc_new = acc_q | ({57'd0, byte_i[6:0]} << shamt);

  // Next state and event decode
  always_comb begin
    in_msg_d  = in_msg_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    vcnt_d    = vcnt_q;
    field_d   = field_q;
    frem_d    = frem_q;
    prim_v    = 1'b0;
    prim_kind = KIND_INT;
    fail_code = ERR_NONE;
    comp      = 1'b0;
    if (step_i && cmd_i == CMD_START) begin
      acc_d   = '0;
      vcnt_d  = '0;
      frem_d  = '0;
      field_d = '0;
      phase_d = PH_KEY;
      if (len_i == '0 || len_i > max_len_q ||
          {11'd0, len_i} > 32'(MAX_MESSAGE_BYTES)) begin
        in_msg_d  = 1'b0;
        rem_d     = '0;
        fail_code = ERR_BAD_LEN;
      end else begin
        in_msg_d = 1'b1;
        rem_d    = len_i;
      end
    end else if (step_i && in_msg_q && rem_q != '0) begin
      rem_d = rem_q - 1'b1;
      if (phase_q == PH_DATA) begin
        prim_v    = 1'b1;
        prim_kind = KIND_DATA;
        if (frem_q != '0) begin
          frem_d = frem_q - 1'b1;
        end
        if (frem_q <= 21'd1) begin
          phase_d = PH_KEY;
        end
      end else begin
        acc_d = acc_new;
        if (byte_i[7]) begin
          if (vcnt_q >= 4'd9) begin
            fail_code = ERR_VARINT;
          end else begin
            vcnt_d = vcnt_q + 1'b1;
            if (rem_d == '0) begin
              fail_code = ERR_TRUNC;
            end
          end
        end else begin
          acc_d  = '0;
          vcnt_d = '0;
          unique case (phase_q)
            PH_KEY: begin
              field_d = acc_new[34:3];
              if (acc_new[2:0] != WireVarint && acc_new[2:0] != WireLenDel) begin
                fail_code = ERR_WIRE;
              end else if (rem_d == '0) begin
                fail_code = ERR_TRUNC;
              end else begin
                phase_d = (acc_new[2:0] == WireVarint) ? PH_VALUE : PH_LEN;
              end
            end
            PH_VALUE: begin
              prim_v    = 1'b1;
              prim_kind = KIND_INT;
              phase_d   = PH_KEY;
            end
            PH_LEN: begin
              if (acc_new > {43'd0, rem_d}) begin
                fail_code = ERR_OVERRUN;
              end else begin
                prim_v    = 1'b1;
                prim_kind = KIND_HDR;
                frem_d    = acc_new[LenW-1:0];
                phase_d   = (acc_new == '0) ? PH_KEY : PH_DATA;
              end
            end
            default: phase_d = phase_q;
          endcase
        end
      end
      if (fail_code != ERR_NONE) begin
        in_msg_d = 1'b0;
        phase_d  = PH_KEY;
      end
      if (in_msg_d && phase_d == PH_KEY && rem_d == '0 && vcnt_d == '0) begin
        comp     = 1'b1;
        in_msg_d = 1'b0;
      end
    end
    if (fail_code != ERR_NONE) begin
      prim_v    = 1'b1;
      prim_kind = KIND_ERR;
    end
  end

  // Result formatting
  always_comb begin
    prim_res                = '0;
    prim_res.kind           = prim_kind;
    prim_res.final_of_input = !comp;
    unique case (prim_kind)
      KIND_INT, KIND_HDR: begin
        prim_res.field_number = field_q;
        prim_res.value        = acc_new;
      end
      KIND_DATA: begin
        prim_res.field_number  = field_q;
        prim_res.payload_byte  = byte_i;
        prim_res.last_of_field = (frem_q <= 21'd1);
      end
      KIND_ERR: prim_res.err_code = fail_code;
      default: prim_res.err_code = ERR_NONE;
    endcase
    comp_res                = '0;
    comp_res.kind           = KIND_DONE;
    comp_res.final_of_input = 1'b1;
  end

  assign res_cnt_o = {1'b0, prim_v} + {1'b0, comp};
  assign res0_o    = prim_v ? prim_res : comp_res;
  assign res1_o    = comp_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      in_msg_q  <= 1'b0;
      phase_q   <= PH_KEY;
      rem_q     <= '0;
      acc_q     <= '0;
      vcnt_q    <= '0;
      field_q   <= '0;
      frem_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      in_msg_q <= in_msg_d;
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      acc_q    <= acc_d;
      vcnt_q   <= vcnt_d;
      field_q  <= field_d;
      frem_q   <= frem_d;
    end
  end

endmodule

`default_nettype wire

### design/pbsd_outq.sv
// Three-entry result queue: takes up to two results a cycle, gives one.
// Depends on pbsd_pkg for the result type.
`default_nettype none

module pbsd_outq import pbsd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire res_t       push0_i,
  input  wire res_t       push1_i,
  output logic            room2_o,
  output logic            valid_o,
  output res_t            head_o,
  input  wire logic       ready_i
);

  localparam int unsigned Depth = 3;

  res_t       mem_q [Depth];
  logic [1:0] rd_q, rd_d;
  logic [1:0] wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] wr_nxt;
  logic       pop;

  function automatic logic [1:0] ptr_add(logic [1:0] p, logic [1:0] n);
    logic [2:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= 3'(Depth)) begin
      s = s - 3'(Depth);
    end
    return s[1:0];
  endfunction

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room2_o = (cnt_q <= 2'd1);
  assign wr_nxt  = ptr_add(wr_q, 2'd1);
  assign rd_d    = pop ? ptr_add(rd_q, 2'd1) : rd_q;
  assign wr_d    = ptr_add(wr_q, push_cnt_i);
  assign cnt_d   = cnt_q + push_cnt_i - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != '0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/protobuf_stream_decoder.sv
// Top level of the protobuf stream decoder: input register, parser, result queue.
// Depends on pbsd_pkg, pbsd_core and pbsd_outq.
//
// Use: the slave stream carries requests. tuser = command (0 start, 1 byte);
// a start opens a message of message_length bytes, each byte request feeds
// one message byte. The master stream gives results: tuser = kind, tlast
// marks the last result caused by one request. max_message_length is set
// through cfg_we_i / cfg_wdata_i while the block is idle.
// Path: a taken request waits in the input register; the parser decodes it into the queue.
// Throughput: one request per cycle while the queue has room for two results; a request
// that yields two results (an item that ends the message) gives both on the master side.
// The rate is set by the single result port fed from the three-entry queue.
// Reset: no message open, limit 1048576, queue empty, input register empty.
// Stall: when the master side holds off, the queue fills and s_axis_tready
// falls once fewer than two entries are free and the input register is full;
// results are never dropped.
`default_nettype none

module protobuf_stream_decoder import pbsd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 1048576
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [31:0]     s_axis_tdata,  // message_length[20:0], data_byte[28:21]
  input  wire logic [0:0]      s_axis_tuser,  // command[0]
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // field_number[31:0], value[95:32], payload_byte[103:96],
  // last_of_field[104], err_code[107:105]
  output logic [111:0]         m_axis_tdata,
  output logic [2:0]           m_axis_tuser,  // kind[2:0]
  output logic                 m_axis_tlast   // final_of_input
);

  logic            in_valid_q, in_valid_d;
  cmd_e            in_cmd_q;
  logic [LenW-1:0] in_len_q;
  logic [7:0]      in_byte_q;
  logic            accept;
  logic            step;
  logic            room2;
  logic [1:0]      res_cnt;
  res_t            res0;
  res_t            res1;
  res_t            head;

  assign s_axis_tready = !in_valid_q || room2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && room2;
  assign in_valid_d    = accept ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser[0]);
      in_len_q  <= s_axis_tdata[20:0];
      in_byte_q <= s_axis_tdata[28:21];
    end
  end

  pbsd_core #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .cmd_i      (in_cmd_q),
    .len_i      (in_len_q),
    .byte_i     (in_byte_q),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  pbsd_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(step ? res_cnt : 2'd0),
    .push0_i   (res0),
    .push1_i   (res1),
    .room2_o   (room2),
    .valid_o   (m_axis_tvalid),
    .head_o    (head),
    .ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, head.err_code, head.last_of_field, head.payload_byte,
                         head.value, head.field_number};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.final_of_input;

endmodule

`default_nettype wire

### design/pbsd_checker.sv
// Port-level checks for the protobuf stream decoder, bound to the top level.
// Depends on pbsd_pkg for the result kind codes.
`default_nettype none

module pbsd_assertions import pbsd_pkg::*; (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // errors and completions end a request's results
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_ERR || m_axis_tuser == KIND_DONE) |->
      m_axis_tlast)
    else $error("error or completion not last of request");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERR |->
      m_axis_tdata[104:0] == '0 && m_axis_tdata[107:105] != ERR_NONE)
    else $error("malformed error result");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DATA |->
      m_axis_tdata[95:32] == '0 && m_axis_tdata[107:105] == ERR_NONE)
    else $error("malformed data-byte result");

endmodule

bind protobuf_stream_decoder pbsd_assertions u_pbsd_assertions (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

### test/pbsd_checker.sv
// Checker for the protobuf stream decoder: watches the config port and both streams,
// predicts the results of every accepted request and compares them in order.
// Depends on pbsd_pkg.
`timescale 1ns / 1ps

module pbsd_checker import pbsd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 1048576
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  input  wire logic            s_axis_tvalid,
  input  wire logic            s_axis_tready,
  input  wire logic [31:0]     s_axis_tdata,  // message_length[20:0], data_byte[28:21]
  input  wire logic [0:0]      s_axis_tuser,  // command[0]
  input  wire logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // field_number[31:0], value[95:32], payload_byte[103:96],
  // last_of_field[104], err_code[107:105]
  input  wire logic [111:0]    m_axis_tdata,
  input  wire logic [2:0]      m_axis_tuser,  // kind[2:0]
  input  wire logic            m_axis_tlast,  // final_of_input
  output int                   fail_count,
  output int                   pending
);

  logic [LenW-1:0]   limit_q;
  logic              open_q;
  phase_e            phase_q;
  logic [LenW-1:0]   msg_left;
  logic [ValueW-1:0] acc;
  logic [3:0]        vcount;
  logic [FieldW-1:0] cur_field;
  logic [LenW-1:0]   field_left;

  res_t pending_results[$];
  res_t step_results[$];
  int   mismatches;

  function automatic res_t make_result(kind_e k, logic [FieldW-1:0] fn, logic [ValueW-1:0] v,
                                       logic [7:0] pb, logic lf, err_e e);
    res_t r;
    r.final_of_input = 1'b0;
    r.kind           = k;
    r.err_code       = e;
    r.last_of_field  = lf;
    r.payload_byte   = pb;
    r.value          = v;
    r.field_number   = fn;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("kind=%0d field=%0h value=%0h byte=%0h last=%0b err=%0d final=%0b",
                     r.kind, r.field_number, r.value, r.payload_byte, r.last_of_field,
                     r.err_code, r.final_of_input);
  endfunction

  task automatic raise_error(input err_e code);
    step_results.push_back(make_result(KIND_ERR, '0, '0, '0, 1'b0, code));
    open_q  = 1'b0;
    phase_q = PH_KEY;
  endtask

  task automatic decode_request(input cmd_e cmd, input logic [LenW-1:0] len,
                                input logic [7:0] b);
    logic [ValueW-1:0] v;
    logic [2:0]        wtype;
    logic [LenW-1:0]   eff_limit;
    res_t              r;
    step_results.delete();
    if (cmd == CMD_START) begin
      eff_limit  = (limit_q > MAX_MESSAGE_BYTES) ? LenW'(MAX_MESSAGE_BYTES) : limit_q;
      acc        = '0;
      vcount     = '0;
      field_left = '0;
      cur_field  = '0;
      phase_q    = PH_KEY;
      if (len == 0 || len > eff_limit) begin
        open_q   = 1'b0;
        msg_left = '0;
        raise_error(ERR_BAD_LEN);
      end else begin
        open_q   = 1'b1;
        msg_left = len;
      end
    end else if (open_q && msg_left != 0) begin
      msg_left--;
      if (phase_q == PH_DATA) begin
        step_results.push_back(make_result(KIND_DATA, cur_field, '0, b, field_left <= 1,
                                           ERR_NONE));
        if (field_left != 0) field_left--;
        if (field_left == 0) phase_q = PH_KEY;
      end else begin
        acc |= ValueW'(b[6:0]) << (7 * vcount);
        if (!b[7]) begin
          v      = acc;
          acc    = '0;
          vcount = '0;
          case (phase_q)
            PH_KEY: begin
              wtype     = v[2:0];
              cur_field = v[34:3];
              if (wtype != WireVarint && wtype != WireLenDel) begin
                raise_error(ERR_WIRE);
              end else if (msg_left == 0) begin
                raise_error(ERR_TRUNC);
              end else begin
                phase_q = (wtype == WireVarint) ? PH_VALUE : PH_LEN;
              end
            end
            PH_VALUE: begin
              step_results.push_back(make_result(KIND_INT, cur_field, v, '0, 1'b0, ERR_NONE));
              phase_q = PH_KEY;
            end
            default: begin
              if (v > ValueW'(msg_left)) begin
                raise_error(ERR_OVERRUN);
              end else begin
                step_results.push_back(make_result(KIND_HDR, cur_field, v, '0, 1'b0,
                                                   ERR_NONE));
                field_left = v[LenW-1:0];
                phase_q    = (v == 0) ? PH_KEY : PH_DATA;
              end
            end
          endcase
        end else if (vcount >= 9) begin
          raise_error(ERR_VARINT);
        end else begin
          vcount++;
          if (msg_left == 0) raise_error(ERR_TRUNC);
        end
      end
      if (open_q && phase_q == PH_KEY && msg_left == 0 && vcount == 0) begin
        step_results.push_back(make_result(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE));
        open_q = 1'b0;
      end
    end
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.final_of_input = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t got, want;
    if (!rst_ni) begin
      limit_q    = MaxLenReset;
      open_q     = 1'b0;
      phase_q    = PH_KEY;
      msg_left   = '0;
      acc        = '0;
      vcount     = '0;
      cur_field  = '0;
      field_left = '0;
      mismatches = 0;
      pending_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.field_number   = m_axis_tdata[31:0];
        got.value          = m_axis_tdata[95:32];
        got.payload_byte   = m_axis_tdata[103:96];
        got.last_of_field  = m_axis_tdata[104];
        got.err_code       = err_e'(m_axis_tdata[107:105]);
        got.kind           = kind_e'(m_axis_tuser);
        got.final_of_input = m_axis_tlast;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_request(cmd_e'(s_axis_tuser[0]), s_axis_tdata[20:0], s_axis_tdata[28:21]);
      end
      fail_count <= mismatches;
      pending    <= pending_results.size();
    end
  end

endmodule

### test/tb_protobuf_stream_decoder.sv
// Testbench top for protobuf_stream_decoder: clock, reset, config writes, request
// stimulus (directed frames, then random well-formed and broken frames) and verdict.
// Depends on pbsd_pkg, protobuf_stream_decoder and pbsd_checker.
`timescale 1ns / 1ps

module tb_protobuf_stream_decoder;
  import pbsd_pkg::*;

  localparam int unsigned MaxBytes = 1048576;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [LenW-1:0] cfg_wdata_i   = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata  = '0;
  logic [0:0]      s_axis_tuser  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [111:0]    m_axis_tdata;
  logic [2:0]      m_axis_tuser;
  logic            m_axis_tlast;
  int              fail_count;
  int              pending;

  logic [7:0]  frame_bytes[$];
  logic [15:0] rx_tick = '0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          items_sent = 0;

  protobuf_stream_decoder #(.MAX_MESSAGE_BYTES(MaxBytes)) dut (.*);

  pbsd_checker #(.MAX_MESSAGE_BYTES(MaxBytes)) u_checker (.*);

  always #6 clk_i = ~clk_i;

  // receiver: always ready, random, periodic, then mostly stalled
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= (rx_tick[2:0] != 3'd0);
      default: m_axis_tready <= (rx_tick[3:0] >= 4'd12);
    endcase
  end

  task automatic send_request(input cmd_e cmd, input logic [LenW-1:0] len,
                              input logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(60, 200);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap_left   = $urandom_range(0, 6);
      end
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
    end
    burst_left--;
    items_sent++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, b, len};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LenW-1:0] val);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic emit_varint(input logic [63:0] v);
    do begin
      frame_bytes.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  task automatic send_tiny();
    send_request(CMD_START, LenW'($urandom_range(1, 2)), 8'($urandom));
    repeat ($urandom_range(1, 2)) send_request(CMD_BYTE, LenW'($urandom), 8'($urandom));
  endtask

  // shapes: <70 well-formed, 70..76 bad wire type, 77..83 overlong varint,
  // 84..89 length overrun, 90..94 wrong announced length, 95..99 noise
  task automatic send_message();
    int          shape;
    int          nfields;
    int          bad_at;
    int          dlen;
    int          announced;
    logic [63:0] key;
    logic [63:0] v;
    logic [2:0]  wtype;
    frame_bytes.delete();
    shape   = $urandom_range(0, 99);
    nfields = $urandom_range(1, 5);
    bad_at  = (shape >= 77 && shape < 90) ? nfields - 1 : $urandom_range(0, nfields - 1);
    for (int i = 0; i < nfields; i++) begin
      wtype = $urandom_range(0, 1) ? WireLenDel : WireVarint;
      if (i == bad_at && shape >= 70 && shape < 77) begin
        do wtype = 3'($urandom_range(0, 7));
        while (wtype == WireVarint || wtype == WireLenDel);
      end
      if (i == bad_at && shape >= 77 && shape < 84) wtype = WireVarint;
      if (i == bad_at && shape >= 84 && shape < 90) wtype = WireLenDel;
      case ($urandom_range(0, 9))
        0:       key = {$urandom, $urandom};
        1, 2:    key = 64'($urandom_range(1, 29'h1fffffff)) << 3;
        default: key = 64'($urandom_range(1, 31)) << 3;
      endcase
      key[2:0] = wtype;
      emit_varint(key);
      if (i == bad_at && shape >= 77 && shape < 84) begin
        repeat (10) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
      end else if (i == bad_at && shape >= 84 && shape < 90) begin
        emit_varint(64'($urandom_range(8, 300)));
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end else if (wtype == WireVarint) begin
        if ($urandom_range(0, 15) == 0) begin
          // ten-byte varint whose last byte may carry bits past bit 63
          repeat (9) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
          frame_bytes.push_back(8'($urandom_range(0, 127)));
        end else begin
          v = {$urandom, $urandom};
          if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(1, 63);
          emit_varint(v);
        end
      end else if (wtype == WireLenDel) begin
        case ($urandom_range(0, 7))
          0:       dlen = 0;
          1:       dlen = $urandom_range(20, 40);
          default: dlen = $urandom_range(1, 8);
        endcase
        emit_varint(64'(dlen));
        repeat (dlen) frame_bytes.push_back(8'($urandom));
      end
    end
    announced = frame_bytes.size();
    if (shape >= 90 && shape < 95) begin
      announced = $urandom_range(0, 1) ? $urandom_range(0, announced - 1)
                                       : announced + $urandom_range(1, 4);
    end else if (shape >= 95) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      announced = $urandom_range(0, 1) ? $urandom_range(0, 21'h1fffff) : frame_bytes.size();
      if ($urandom_range(0, 1)) send_request(CMD_BYTE, LenW'($urandom), 8'($urandom));
    end
    send_request(CMD_START, LenW'(announced), 8'($urandom));
    foreach (frame_bytes[i]) send_request(CMD_BYTE, LenW'($urandom), frame_bytes[i]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_BYTE, 21'h0, 8'hff);
    send_request(CMD_START, 21'h0, 8'h00);
    send_request(CMD_START, 21'h1fffff, 8'hff);
    send_request(CMD_START, 21'h100000, 8'h00);
    // varint 150, two-byte bytes field, empty bytes field, then complete
    send_request(CMD_START, 21'd9, 8'h00);
    send_request(CMD_BYTE, 21'h0, 8'h08);
    send_request(CMD_BYTE, 21'h0, 8'h96);
    send_request(CMD_BYTE, 21'h0, 8'h01);
    send_request(CMD_BYTE, 21'h0, 8'h12);
    send_request(CMD_BYTE, 21'h0, 8'h02);
    send_request(CMD_BYTE, 21'h0, 8'hab);
    send_request(CMD_BYTE, 21'h0, 8'hcd);
    send_request(CMD_BYTE, 21'h0, 8'h1a);
    send_request(CMD_BYTE, 21'h0, 8'h00);
    // unsupported wire type, byte after it ignored
    send_request(CMD_START, 21'd2, 8'h00);
    send_request(CMD_BYTE, 21'h0, 8'h0b);
    send_request(CMD_BYTE, 21'h0, 8'h00);
    // message ends right after a key
    send_request(CMD_START, 21'd1, 8'h00);
    send_request(CMD_BYTE, 21'h0, 8'h08);
    // field length past the end of the message
    send_request(CMD_START, 21'd4, 8'h00);
    send_request(CMD_BYTE, 21'h0, 8'h12);
    send_request(CMD_BYTE, 21'h0, 8'h05);

    write_limit(21'd1);
    repeat (15) send_tiny();
    write_limit(LenW'($urandom_range(24, 64)));
    while (items_sent < 450) send_message();
    write_limit(MaxLenReset);
    while (items_sent < 850) send_message();
    write_limit(LenW'($urandom_range(65, 1048576)));
    while (items_sent < 1150) send_message();

    drain_and_settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
design/pbsd_pkg.sv
design/pbsd_core.sv
design/pbsd_outq.sv
design/protobuf_stream_decoder.sv
design/pbsd_checker.sv
test/pbsd_checker.sv
test/tb_protobuf_stream_decoder.sv
